// File: sv/bcpm_pkg.sv
// ----------------------------------------------------------------------------
// bcpm_pkg: shared types and constants for the binary-by-coefficient multiplier
// Field widths, beat packing and the control bundle broadcast along the chain.
// ----------------------------------------------------------------------------
package bcpm_pkg;

    localparam int TERMS_DEF = 64;          // default number of terms per product

    localparam int COEF_W    = 9;           // a_coef width
    localparam int IDX_W     = 7;           // coef_index width
    localparam int VAL_W     = 15;          // coef_value width

    localparam int S_TDATA_W = 16;          // x_bit + a_coef, padded to bytes
    localparam int M_TDATA_W = 24;          // coef_index + coef_value, padded

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              add_en;          // fold the current item into the sums
        logic              shift_en;        // move partial sums one cell down
        logic              x_bit;           // current item's bit
        logic [COEF_W-1:0] a_coef;          // current item's coefficient
    } cell_ctrl_t;

endpackage

// File: sv/binary_by_coef_poly_multiply.sv
// ----------------------------------------------------------------------------
// binary_by_coef_poly_multiply: schoolbook product of a bit vector and a
// coefficient vector, one coefficient beat per cycle while m_tready does not stall it.
// ----------------------------------------------------------------------------
// Input beat k carries x_k and a_k of a TERMS-term product. Beat k yields
// coefficient k of the 2*TERMS-1 term linear convolution in the cycle after it
// is taken. Beat TERMS-1 is followed by TERMS-1 more output beats carrying
// degrees TERMS..2*TERMS-2; the last one has m_tlast set.
// A row of TERMS cells holds the operand terms and one partial sum each; the
// sums shift toward the output one cell per cycle while beats are taken or
// the chain drains, and cell 0 feeds a single output register. After the
// final beat of a product the input is held off while the chain drains.
// While a beat waits on m_tready the output holds and s_tready drops; no
// beat is lost. Reset clears the sums, the item counter and the output valid;
// the stored terms need no clearing since a cell only uses its terms once its
// index is below the item counter. After a product the chain is empty again
// and the next product starts from zero.
// ----------------------------------------------------------------------------
module binary_by_coef_poly_multiply #(
    parameter int TERMS = bcpm_pkg::TERMS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcpm_pkg::S_TDATA_W-1:0] s_tdata,   // x_bit, a_coef, zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcpm_pkg::M_TDATA_W-1:0] m_tdata,   // coef_index, coef_value, pad
    output logic                           m_tlast    // is_last
);
    import bcpm_pkg::*;

    localparam int CNT_W = $clog2(TERMS);
    localparam int DEG_W = $clog2(2 * TERMS - 1);
    localparam logic [DEG_W-1:0] DEG_END_RUN = DEG_W'(TERMS - 1);
    localparam logic [DEG_W-1:0] DEG_FIRST_UP = DEG_W'(TERMS);
    localparam logic [DEG_W-1:0] DEG_LAST = DEG_W'(2 * TERMS - 2);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             state_reg, state_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [VAL_W-1:0] m_val_reg, m_val_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             accept;
    logic             drain_go;
    logic             at_last;
    logic [DEG_W+IDX_W-1:0] deg_ext;
    cell_ctrl_t       ctrl;

    logic [VAL_W-1:0] acc_chain [TERMS+1];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_RUN) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign drain_go = (state_reg == ST_DRAIN) && out_free;
    assign at_last  = deg_reg == DEG_LAST;
    assign deg_ext  = {{IDX_W{1'b0}}, deg_reg};

    always_comb begin
        ctrl.add_en   = accept;
        ctrl.shift_en = accept || drain_go;
        ctrl.x_bit    = s_tdata[0];
        ctrl.a_coef   = s_tdata[COEF_W:1];
    end

    assign acc_chain[TERMS] = '0;

    for (genvar i = 0; i < TERMS; i++) begin : g_cell
        bcpm_cell #(
            .TERMS    (TERMS),
            .CELL_IDX (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .item_idx (deg_reg[CNT_W-1:0]),
            .acc_in   (acc_chain[i+1]),
            .acc_out  (acc_chain[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        deg_next     = deg_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_val_next   = m_val_reg;
        m_last_next  = m_last_reg;
        if (accept || drain_go) begin
            m_valid_next = 1'b1;
            m_idx_next   = deg_ext[IDX_W-1:0];
            m_val_next   = acc_chain[0];
            m_last_next  = drain_go && at_last;
        end
        if (accept) begin
            if (deg_reg == DEG_END_RUN) begin
                state_next = ST_DRAIN;
                deg_next   = DEG_FIRST_UP;
            end else begin
                deg_next = deg_reg + DEG_W'(1);
            end
        end else if (drain_go) begin
            if (at_last) begin
                state_next = ST_RUN;
                deg_next   = '0;
            end else begin
                deg_next = deg_reg + DEG_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            deg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            deg_reg     <= deg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_idx_reg  <= m_idx_next;
        m_val_reg  <= m_val_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - IDX_W - VAL_W)'(0), m_val_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: sv/bcpm_cell.sv
// ----------------------------------------------------------------------------
// bcpm_cell: one cell of the convolution chain
// Holds term CELL_IDX of both operands and the partial sum of one degree.
// The partial sum moves one cell toward the output on every shift.
// ----------------------------------------------------------------------------
module bcpm_cell #(
    parameter int TERMS    = bcpm_pkg::TERMS_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bcpm_pkg::cell_ctrl_t       ctrl,
    input  logic [$clog2(TERMS)-1:0]   item_idx,
    input  logic [bcpm_pkg::VAL_W-1:0] acc_in,
    output logic [bcpm_pkg::VAL_W-1:0] acc_out
);
    import bcpm_pkg::*;

    localparam int CNT_W = $clog2(TERMS);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    logic              x_reg;
    logic [COEF_W-1:0] a_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic [VAL_W-1:0]  acc_next;

    logic              filled;
    logic              here;
    logic [COEF_W-1:0] x_new_part;
    logic [COEF_W-1:0] x_old_part;
    logic [COEF_W:0]   term;

    always_comb begin
        filled     = MY_IDX < item_idx;
        here       = MY_IDX == item_idx;
        // new bit against stored coef, stored bit against new coef
        x_new_part = ctrl.x_bit ? a_reg : '0;
        x_old_part = x_reg ? ctrl.a_coef : '0;
        if (filled) begin
            term = {1'b0, x_new_part} + {1'b0, x_old_part};
        end else if (here) begin
            term = {1'b0, (ctrl.x_bit ? ctrl.a_coef : COEF_W'(0))};
        end else begin
            term = '0;
        end
        acc_out  = acc_reg + (ctrl.add_en ? VAL_W'(term) : VAL_W'(0));
        acc_next = ctrl.shift_en ? acc_in : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.add_en && here) begin
            x_reg <= ctrl.x_bit;
            a_reg <= ctrl.a_coef;
        end
    end

endmodule

// File: sv/bcpm_checker.sv
// ----------------------------------------------------------------------------
// bcpm_checker: port-level checks for the polynomial multiplier
// Watches both streams and the tlast beat, bound to the top level.
// ----------------------------------------------------------------------------
module bcpm_checker #(
    parameter int TERMS = bcpm_pkg::TERMS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [bcpm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bcpm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import bcpm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * TERMS - 2);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // every taken input beat gives an output beat next cycle
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input beat gave no output beat");

    // tlast only on the top degree
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[IDX_W-1:0] == LAST_IDX)
        else $error("tlast on wrong coefficient");

    // a waiting input beat holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat changed while waiting");

    // a stalled output also stalls the input
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind binary_by_coef_poly_multiply bcpm_checker #(.TERMS(TERMS)) u_bcpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_by_coef_poly_multiply
// Streams x/a term beats into the multiplier, predicts every product
// coefficient with a behavioral convolution and checks each output beat in
// order, with random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb;

    import bcpm_pkg::*;

    localparam int TERMS   = TERMS_DEF;
    localparam int MAX_DEG = 2 * TERMS - 2;

    typedef struct {
        logic              x;
        logic [COEF_W-1:0] a;
        int                gap;     // idle cycles before the beat is offered
        bit                hold;    // wait for the output side to drain first
    } term_beat_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             last;
    } coef_beat_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    term_beat_t pending_terms[$];
    coef_beat_t coef_expected[$];

    // predicted multiplier state
    logic              held_x [TERMS];
    logic [COEF_W-1:0] held_a [TERMS];
    int                next_pos = 0;

    int  mismatches = 0;
    bit  drv_active = 1'b0;
    int  gap_count  = 0;
    int  stall_left = 0;
    bit  rx_calm    = 1'b0;
    term_beat_t cur_term;

    int dir_a [25] = '{511, 511, 0, 0, 511, 256, 257, 1, 256, 511, 255, 1, 170,
                       341, 0, 0, 511, 0, 511, 256, 511, 2, 128, 384, 511};
    bit dir_x [25] = '{1, 1, 0, 1, 0, 1, 1, 1, 0, 1, 1, 0, 1,
                       1, 0, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1};

    binary_by_coef_poly_multiply #(
        .TERMS(TERMS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic coef_beat_t conv_coef(int d);
        coef_beat_t c;
        int sum;
        sum = 0;
        for (int j = 0; j < TERMS && j <= d; j++) begin
            if (d - j < TERMS && held_x[j])
                sum += held_a[d - j];
        end
        c.idx  = d[IDX_W-1:0];
        c.val  = sum[VAL_W-1:0];
        c.last = (d == MAX_DEG);
        return c;
    endfunction

    // store one term and queue the coefficients it completes
    task automatic absorb_term(input logic x, input logic [COEF_W-1:0] a);
        int pos;
        pos = (next_pos >= TERMS) ? 0 : next_pos;
        held_x[pos] = x;
        held_a[pos] = a;
        coef_expected.push_back(conv_coef(pos));
        if (pos == TERMS - 1) begin
            for (int d = TERMS; d <= MAX_DEG; d++)
                coef_expected.push_back(conv_coef(d));
            for (int j = 0; j < TERMS; j++) begin
                held_x[j] = 1'b0;
                held_a[j] = '0;
            end
            next_pos = 0;
        end else begin
            next_pos = pos + 1;
        end
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < 10)
            $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic term_beat_t mk_term(logic x, int a, int gap, bit hold);
        term_beat_t t;
        t.x    = x;
        t.a    = a[COEF_W-1:0];
        t.gap  = gap;
        t.hold = hold;
        return t;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            drv_active = 1'b0;
            gap_count  = 0;
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (drv_active && s_tready) begin
                absorb_term(cur_term.x, cur_term.a);
                drv_active = 1'b0;
                gap_count  = 0;
            end
            if (!drv_active && pending_terms.size() != 0) begin
                if (gap_count < pending_terms[0].gap) begin
                    gap_count++;
                end else if (!pending_terms[0].hold || coef_expected.size() == 0) begin
                    cur_term   = pending_terms.pop_front();
                    drv_active = 1'b1;
                end
            end
            s_tvalid <= drv_active;
            if (drv_active)
                s_tdata <= {{(S_TDATA_W - COEF_W - 1){1'b0}}, cur_term.a, cur_term.x};
        end
    end

    // monitor
    always @(posedge aclk) begin
        coef_beat_t exp_c;
        if (!aresetn) begin
            stall_left = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (coef_expected.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat idx=%0d val=%0d last=%0b",
                        m_tdata[IDX_W-1:0], m_tdata[IDX_W+VAL_W-1:IDX_W], m_tlast));
                end else begin
                    exp_c = coef_expected.pop_front();
                    if (m_tdata[IDX_W-1:0] !== exp_c.idx
                            || m_tdata[IDX_W+VAL_W-1:IDX_W] !== exp_c.val
                            || m_tlast !== exp_c.last)
                        note_mismatch($sformatf(
                            "exp idx=%0d val=%0d last=%0b, got idx=%0d val=%0d last=%0b",
                            exp_c.idx, exp_c.val, exp_c.last, m_tdata[IDX_W-1:0],
                            m_tdata[IDX_W+VAL_W-1:IDX_W], m_tlast));
                end
                // back-pressure style changes per product
                if (m_tlast)
                    rx_calm = ($urandom_range(0, 2) == 0);
                stall_left = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int  mode;
        int  hold_at;
        bit  calm;
        logic x;
        int  a;

        // directed corner beats open the first product
        for (int i = 0; i < 25; i++)
            pending_terms.push_back(mk_term(dir_x[i], dir_a[i], $urandom_range(0, 5), 1'b0));

        for (int p = 0; p < 4; p++) begin
            mode    = (p == 1) ? 3 : $urandom_range(0, 2);
            calm    = (p == 1) || ($urandom_range(0, 3) == 0);
            hold_at = (p == 1) ? 0 : (p == 2) ? $urandom_range(1, TERMS - 1) : -1;
            for (int i = (p == 0) ? 25 : 0; i < TERMS; i++) begin
                case (mode)
                    0: begin
                        x = 1'($urandom_range(0, 1));
                        a = $urandom_range(0, 511);
                    end
                    1: begin
                        x = 1'($urandom_range(0, 1));
                        a = $urandom_range(0, 256);
                    end
                    2: begin
                        x = ($urandom_range(0, 7) == 0);
                        a = $urandom_range(0, 511);
                    end
                    default: begin
                        // all-ones product: largest possible sums
                        x = 1'b1;
                        a = 511;
                    end
                endcase
                pending_terms.push_back(mk_term(x, a, calm ? 0 : $urandom_range(0, 5),
                                                i == hold_at));
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_terms.size() != 0 || drv_active || coef_expected.size() != 0)
            @(posedge aclk);
        repeat (2 * TERMS + 10) @(posedge aclk);

        if (coef_expected.size() != 0)
            note_mismatch($sformatf("%0d coefficients never arrived", coef_expected.size()));

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
sv/bcpm_pkg.sv
sv/bcpm_cell.sv
sv/binary_by_coef_poly_multiply.sv
sv/bcpm_checker.sv
tb/sv/tb.sv
